/* sv/tpi_pkg.sv */
// tpi_pkg: types, codes, constants and the CORDIC angle table shared by the
// trajectory point interpolator modules. Depends on nothing.
package tpi_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int CORDIC_STEPS   = 24;
	localparam int DIV_STEPS      = 72;
	localparam logic signed [27:0] HALF_PI_Z = 28'sd26353589;
	localparam logic signed [27:0] HEAD_MAX  = 28'sd25736;

	localparam logic [1:0] CMD_QUERY  = 2'd0;
	localparam logic [1:0] CMD_FIRST  = 2'd1;
	localparam logic [1:0] CMD_APPEND = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ0, ST_LOAD0, ST_READ, ST_CHECK,
		ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_DIV, ST_DIVEND,
		ST_CINIT, ST_CSTEP, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {MODE_ZERO, MODE_HOLD, MODE_INTERP} mode_t;

	typedef struct packed {
		logic [39:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] yaw;
	} point_t;

	typedef struct packed {
		logic acc;
		logic q_start;
		logic ld0;
		logic chk;
		logic mul0;
		logic mul1;
		logic mul2;
		logic mul3;
		logic div_step;
		logic div_end;
		logic cord_init;
		logic cord_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic one_pt;
		logic before_first;
		logic found;
		logic last_idx;
		logic div_last;
		logic cord_last;
		logic lane_y;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [23:0] atan_tab(input logic [4:0] i);
		logic [23:0] v;
		case (i)
			5'd0:  v = 24'd13176795;
			5'd1:  v = 24'd7778716;
			5'd2:  v = 24'd4110060;
			5'd3:  v = 24'd2086331;
			5'd4:  v = 24'd1047214;
			5'd5:  v = 24'd524117;
			5'd6:  v = 24'd262123;
			5'd7:  v = 24'd131069;
			5'd8:  v = 24'd65536;
			5'd9:  v = 24'd32768;
			5'd10: v = 24'd16384;
			5'd11: v = 24'd8192;
			5'd12: v = 24'd4096;
			5'd13: v = 24'd2048;
			5'd14: v = 24'd1024;
			5'd15: v = 24'd512;
			5'd16: v = 24'd256;
			5'd17: v = 24'd128;
			5'd18: v = 24'd64;
			5'd19: v = 24'd32;
			5'd20: v = 24'd16;
			5'd21: v = 24'd8;
			5'd22: v = 24'd4;
			5'd23: v = 24'd2;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage

/* sv/tpi_ram.sv */
// tpi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/tpi_ctrl.sv */
// tpi_ctrl: sequencer for the interpolator; issues datapath commands.
// Depends on tpi_pkg.
module tpi_ctrl import tpi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] cmd,
	output logic       in_ready,
	input  dp_stat_t   st,
	output dp_cmd_t    dc
);
	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && cmd == CMD_QUERY) begin
					state_nxt = st.empty ? ST_FINISH : ST_READ0;
				end
			end
			ST_READ0: state_nxt = ST_LOAD0;
			ST_LOAD0: state_nxt = (st.one_pt || st.before_first) ? ST_FINISH : ST_READ;
			ST_READ:  state_nxt = ST_CHECK;
			ST_CHECK: begin
				if (st.found) begin
					state_nxt = ST_MUL0;
				end else if (st.last_idx) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_READ;
				end
			end
			ST_MUL0:   state_nxt = ST_MUL1;
			ST_MUL1:   state_nxt = ST_MUL2;
			ST_MUL2:   state_nxt = ST_MUL3;
			ST_MUL3:   state_nxt = ST_DIV;
			ST_DIV:    state_nxt = st.div_last ? ST_DIVEND : ST_DIV;
			ST_DIVEND: state_nxt = st.lane_y ? ST_CINIT : ST_MUL0;
			ST_CINIT:  state_nxt = ST_CSTEP;
			ST_CSTEP:  state_nxt = st.cord_last ? ST_FINISH : ST_CSTEP;
			ST_FINISH: state_nxt = st.out_busy ? ST_FINISH : ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		dc           = '0;
		dc.acc       = (state_q == ST_IDLE) && in_valid;
		dc.q_start   = dc.acc && cmd == CMD_QUERY;
		dc.ld0       = (state_q == ST_LOAD0);
		dc.chk       = (state_q == ST_CHECK);
		dc.mul0      = (state_q == ST_MUL0);
		dc.mul1      = (state_q == ST_MUL1);
		dc.mul2      = (state_q == ST_MUL2);
		dc.mul3      = (state_q == ST_MUL3);
		dc.div_step  = (state_q == ST_DIV);
		dc.div_end   = (state_q == ST_DIVEND);
		dc.cord_init = (state_q == ST_CINIT);
		dc.cord_step = (state_q == ST_CSTEP);
		dc.out_load  = (state_q == ST_FINISH) && !st.out_busy;
	end
endmodule

/* sv/tpi_dp.sv */
// tpi_dp: point store, segment scan registers, shared multiply/divide unit,
// CORDIC vectoring unit and result register. Depends on tpi_pkg, tpi_ram.
module tpi_dp import tpi_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dc,
	output dp_stat_t           st,
	input  logic [1:0]         cmd,
	input  logic [39:0]        sample_time,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [15:0] point_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading,
	output logic               traj_present,
	output logic               at_end,
	output logic               points_dropped
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = $bits(point_t);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [AW-1:0] idx_q;
	logic [39:0]   now_q;
	mode_t         mode_q;
	logic          end_q;
	point_t        prev_q, cur_q, rd_pt, wr_pt;
	logic          we;
	logic [AW-1:0] waddr;
	logic [PW-1:0] rdata;

	// arithmetic
	logic [39:0]  e_q, dt_q;
	logic         lane_q, neg_q;
	logic [31:0]  mag_q;
	logic [51:0]  pp_q, pp2_q, prod;
	logic [71:0]  num_q;
	logic [39:0]  rem_q;
	logic [6:0]   cnt_q;
	logic [31:0]  res_x_q, res_y_q, lane_a, lane_b, lerp_res;
	logic [32:0]  diff, dx, dy;
	logic [40:0]  r2;
	logic         ge;
	logic signed [59:0] cx_q, cy_q, x0, y0, xs, ys;
	logic signed [27:0] cz_q, hz;
	logic         zero_q;
	logic [15:0]  head_val;
	logic         out_valid_q;

	assign wr_pt = '{t: sample_time, x: point_x, y: point_y, yaw: point_yaw};
	assign rd_pt = point_t'(rdata);
	assign we    = dc.acc && (cmd == CMD_FIRST ||
	                          (cmd == CMD_APPEND && count_q < CW'(MAX_POINTS)));
	assign waddr = (cmd == CMD_FIRST) ? '0 : count_q[AW-1:0];

	tpi_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(PW'(wr_pt)),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (dc.acc) begin
			if (cmd == CMD_FIRST) begin
				count_q <= CW'(1);
				ovf_q   <= 1'b0;
			end else if (cmd == CMD_APPEND) begin
				if (count_q < CW'(MAX_POINTS)) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// status
	assign st.empty        = (count_q == '0);
	assign st.one_pt       = (count_q == CW'(1));
	assign st.before_first = now_q < rd_pt.t;
	assign st.found        = (prev_q.t <= now_q) && (now_q < rd_pt.t);
	assign st.last_idx     = (CW'(idx_q) + CW'(1)) == count_q;
	assign st.div_last     = (cnt_q == 7'(DIV_STEPS - 1));
	assign st.cord_last    = (cnt_q == 7'(CORDIC_STEPS - 1));
	assign st.lane_y       = lane_q;
	assign st.out_busy     = out_valid_q && !out_ready;

	// scan
	always_ff @(posedge clk) begin
		if (dc.q_start) begin
			now_q  <= sample_time;
			mode_q <= MODE_ZERO;
			end_q  <= 1'b0;
			idx_q  <= '0;
		end
		if (dc.ld0) begin
			prev_q <= rd_pt;
			mode_q <= MODE_HOLD;
			end_q  <= st.one_pt;
			idx_q  <= AW'(1);
		end
		if (dc.chk) begin
			if (st.found) begin
				cur_q  <= rd_pt;
				mode_q <= MODE_INTERP;
				e_q    <= now_q - prev_q.t;
				dt_q   <= rd_pt.t - prev_q.t;
				lane_q <= 1'b0;
			end else begin
				prev_q <= rd_pt;
				if (st.last_idx) begin
					end_q <= 1'b1;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
		end
		if (dc.div_end) begin
			lane_q <= 1'b1;
		end
	end

	// lerp: a + round((b-a) * e / dt), one lane at a time
	assign lane_a   = lane_q ? prev_q.y : prev_q.x;
	assign lane_b   = lane_q ? cur_q.y : cur_q.x;
	assign diff     = {lane_b[31], lane_b} - {lane_a[31], lane_a};
	assign prod     = mag_q * (dc.mul1 ? {12'b0, e_q[19:0]} : {12'b0, e_q[39:20]});
	assign r2       = {rem_q, num_q[71]};
	assign ge       = r2 >= {1'b0, dt_q};
	assign lerp_res = neg_q ? lane_a - num_q[31:0] : lane_a + num_q[31:0];

	always_ff @(posedge clk) begin
		if (dc.mul0) begin
			neg_q <= diff[32];
			mag_q <= diff[32] ? 32'(-diff) : diff[31:0];
		end
		if (dc.mul1) begin
			pp_q <= prod;
		end
		if (dc.mul2) begin
			pp2_q <= prod;
		end
		if (dc.mul3) begin
			num_q <= {20'b0, pp_q} + {pp2_q, 20'b0} + {33'b0, dt_q[39:1]};
			rem_q <= '0;
		end
		if (dc.div_step) begin
			rem_q <= ge ? 40'(r2 - {1'b0, dt_q}) : r2[39:0];
			num_q <= {num_q[70:0], ge};
		end
		if (dc.div_end) begin
			if (lane_q) begin
				res_y_q <= lerp_res;
			end else begin
				res_x_q <= lerp_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (dc.mul3 || dc.cord_init) begin
			cnt_q <= '0;
		end else if (dc.div_step || dc.cord_step) begin
			cnt_q <= cnt_q + 7'd1;
		end
	end

	// CORDIC atan2 of the segment direction
	assign dx = {cur_q.x[31], cur_q.x} - {prev_q.x[31], prev_q.x};
	assign dy = {cur_q.y[31], cur_q.y} - {prev_q.y[31], prev_q.y};
	assign x0 = {{3{dx[32]}}, dx, 24'b0};
	assign y0 = {{3{dy[32]}}, dy, 24'b0};
	assign xs = cx_q >>> cnt_q;
	assign ys = cy_q >>> cnt_q;

	always_ff @(posedge clk) begin
		if (dc.cord_init) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (x0 < 0) begin
				if (y0 >= 0) begin
					cx_q <= y0;
					cy_q <= -x0;
					cz_q <= HALF_PI_Z;
				end else begin
					cx_q <= -y0;
					cy_q <= x0;
					cz_q <= -HALF_PI_Z;
				end
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end
		if (dc.cord_step) begin
			if (!cy_q[59]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + $signed({4'b0, atan_tab(cnt_q[4:0])});
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - $signed({4'b0, atan_tab(cnt_q[4:0])});
			end
		end
	end

	assign hz = (cz_q + 28'sd1024) >>> 11;
	always_comb begin
		if (zero_q) begin
			head_val = '0;
		end else if (hz > HEAD_MAX) begin
			head_val = HEAD_MAX[15:0];
		end else if (hz < -HEAD_MAX) begin
			head_val = 16'(-HEAD_MAX);
		end else begin
			head_val = hz[15:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dc.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dc.out_load) begin
			traj_present   <= !st.empty;
			at_end         <= end_q;
			points_dropped <= ovf_q;
			case (mode_q)
				MODE_HOLD: begin
					pos_x   <= prev_q.x;
					pos_y   <= prev_q.y;
					heading <= prev_q.yaw;
				end
				MODE_INTERP: begin
					pos_x   <= res_x_q;
					pos_y   <= res_y_q;
					heading <= head_val;
				end
				default: begin
					pos_x   <= '0;
					pos_y   <= '0;
					heading <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dc.out_load |-> !(out_valid_q && !out_ready))
		else $error("result overwritten while pending");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond capacity");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		dc.chk |-> (CW'(idx_q) < count_q))
		else $error("scan index past stored points");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		dc.div_step |-> cnt_q < 7'(DIV_STEPS))
		else $error("divider ran too long");
endmodule

/* sv/trajectory_point_interpolator.sv */
// trajectory_point_interpolator: top level, joins controller and datapath.
// Depends on tpi_pkg, tpi_ctrl, tpi_dp (and tpi_ram below it).
//
// Usage:
// - Input channel (in_valid/in_ready) carries one item: cmd, sample_time and
//   the point fields. cmd FIRST starts a new trajectory with this point,
//   APPEND adds a point (dropped with points_dropped set once MAX_POINTS are
//   stored), QUERY asks for the pose at sample_time. Code 3 is ignored.
// - Loads produce no result. One item is worked at a time;
//   in_ready is high only between items.
// - A query scans the point memory one point at a time (one registered RAM
//   read per point) to find a hold result or the segment to interpolate.
//   An interpolated result adds two multiply/divide passes (x then y, one
//   quotient bit a cycle) and a CORDIC pass for the heading.
// - Output channel (out_valid/out_ready) has its own result register; a new
//   item is taken while a result waits. A finished query holds if the
//   receiver still stalls on the previous result.
// - Reset empties the trajectory and clears the overflow flag; the point
//   memory itself is not cleared and is read only below the point count.
module trajectory_point_interpolator import tpi_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [39:0]        sample_time,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [15:0] point_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading,
	output logic               traj_present,
	output logic               at_end,
	output logic               points_dropped
);
	dp_cmd_t  dc;
	dp_stat_t st;

	// sequencer: scan, multiply, divide, CORDIC, result hand-off
	tpi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.in_ready(in_ready),
		.st      (st),
		.dc      (dc)
	);

	// point store and all arithmetic
	tpi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dc            (dc),
		.st            (st),
		.cmd           (cmd),
		.sample_time   (sample_time),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_yaw     (point_yaw),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading       (heading),
		.traj_present  (traj_present),
		.at_end        (at_end),
		.points_dropped(points_dropped)
	);
endmodule

/* dv/trajectory_point_interpolator_test.sv */
// Self-checking testbench for trajectory_point_interpolator: loads trajectories,
// queries poses and compares each result with a built-in pose predictor.
// Depends on tpi_pkg and the trajectory_point_interpolator RTL.
module trajectory_point_interpolator_test;
	import tpi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = DEF_MAX_POINTS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_QUERY;
	logic [39:0] sample_time = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [15:0] point_yaw = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading;
	logic traj_present, at_end, points_dropped;

	always #2 clk = ~clk;

	trajectory_point_interpolator dut (.*);

	// One expected pose per query.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] hd;
		logic present;
		logic held_end;
		logic dropped;
	} pose_t;

	pose_t pending_poses[$];

	// Predictor copy of the trajectory store.
	logic [39:0] trk_t[NPTS];
	longint trk_x[NPTS];
	longint trk_y[NPTS];
	longint trk_yaw[NPTS];
	int trk_count = 0;
	bit trk_overflow = 0;

	int errors = 0;
	int queries_seen = 0;
	int loads_sent = 0;
	int idle_cycles = 0;
	bit allow_gaps = 1;

	// Sorted-ish time base for random trajectories.
	logic [39:0] next_stamp;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	// a + round((b-a)*e/dt), ties away from zero; e < dt < 2^40
	function automatic longint interp(longint a, longint b, logic [39:0] e,
			logic [39:0] dt);
		longint d;
		logic [79:0] prod;
		logic [79:0] q;
		d = b - a;
		prod = (d < 0 ? 80'(-d) : 80'(d)) * 80'(e) + 80'(dt >> 1);
		q = prod / 80'(dt);
		return d < 0 ? a - longint'(q) : a + longint'(q);
	endfunction

	function automatic longint cordic_heading(longint dx, longint dy);
		longint x, y, z, t, xs, ys, h;
		x = dx <<< 24;
		y = dy <<< 24;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = longint'(HALF_PI_Z);
			end else begin
				t = x; x = -y; y = t; z = -longint'(HALF_PI_Z);
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(atan_tab(5'(i)));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(atan_tab(5'(i)));
			end
		end
		h = (z + 1024) >>> 11;
		if (h > longint'(HEAD_MAX)) h = longint'(HEAD_MAX);
		if (h < -longint'(HEAD_MAX)) h = -longint'(HEAD_MAX);
		return h;
	endfunction

	// Updates the trajectory copy; queues a pose for queries.
	task automatic predict_pose(logic [1:0] c, logic [39:0] tm, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [15:0] pyaw);
		pose_t p;
		int k;
		if (c == CMD_FIRST) begin
			trk_t[0] = tm; trk_x[0] = longint'(px); trk_y[0] = longint'(py);
			trk_yaw[0] = longint'(pyaw);
			trk_count = 1;
			trk_overflow = 0;
		end else if (c == CMD_APPEND) begin
			if (trk_count < NPTS) begin
				trk_t[trk_count] = tm; trk_x[trk_count] = longint'(px);
				trk_y[trk_count] = longint'(py); trk_yaw[trk_count] = longint'(pyaw);
				trk_count++;
			end else
				trk_overflow = 1;
		end else if (c == CMD_QUERY) begin
			p = '{default: 0};
			p.present = trk_count > 0;
			p.dropped = trk_overflow;
			if (trk_count == 1) begin
				p.x = 32'(trk_x[0]); p.y = 32'(trk_y[0]); p.hd = 16'(trk_yaw[0]);
				p.held_end = 1;
			end else if (trk_count >= 2) begin
				if (tm < trk_t[0]) begin
					// before the first point: hold it, not flagged as end
					p.x = 32'(trk_x[0]); p.y = 32'(trk_y[0]); p.hd = 16'(trk_yaw[0]);
				end else begin
					for (k = 0; k + 1 < trk_count; k++)
						if (trk_t[k] <= tm && tm < trk_t[k+1])
							break;
					if (k + 1 < trk_count) begin
						p.x = 32'(interp(trk_x[k], trk_x[k+1], tm - trk_t[k],
							trk_t[k+1] - trk_t[k]));
						p.y = 32'(interp(trk_y[k], trk_y[k+1], tm - trk_t[k],
							trk_t[k+1] - trk_t[k]));
						p.hd = 16'(cordic_heading(trk_x[k+1] - trk_x[k],
							trk_y[k+1] - trk_y[k]));
					end else begin
						// past the end, zero-length or unsorted: last point
						p.x = 32'(trk_x[trk_count-1]); p.y = 32'(trk_y[trk_count-1]);
						p.hd = 16'(trk_yaw[trk_count-1]); p.held_end = 1;
					end
				end
			end
			pending_poses.push_back(p);
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: one item per call, random gap first
	// ---------------------------------------------------------------
	task automatic send_item(logic [1:0] c, logic [39:0] tm, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [15:0] pyaw);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sample_time <= tm;
		point_x <= px;
		point_y <= py;
		point_yaw <= pyaw;
		do @(posedge clk); while (!in_ready);
		predict_pose(c, tm, px, py, pyaw);
		if (c != CMD_QUERY) loads_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		// loads produce nothing, so give an in-flight query time to finish
		repeat (2 * NPTS + 200) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom);
			default: return $signed(32'($urandom_range(0, 40000))) - 20000;
		endcase
	endfunction

	function automatic logic signed [15:0] rand_yaw();
		return 16'($signed($urandom_range(0, 51472)) - 25736);
	endfunction

	// ---------------------------------------------------------------
	// Receiver and checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (allow_gaps && $urandom_range(0, 5) == 0)
			idle_cycles = $urandom_range(1, 13);
		if (idle_cycles > 0) begin
			idle_cycles--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		pose_t e;
		if (arst_n && out_valid && out_ready) begin
			queries_seen++;
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d", $realtime, pos_x, pos_y);
				errors++;
			end else begin
				e = pending_poses.pop_front();
				if (pos_x !== e.x || pos_y !== e.y || heading !== e.hd ||
						traj_present !== e.present || at_end !== e.held_end ||
						points_dropped !== e.dropped) begin
					$display("%0t: mismatch expected x=%0d y=%0d hd=%0d p=%0b e=%0b d=%0b",
						$realtime, e.x, e.y, e.hd, e.present, e.held_end, e.dropped);
					$display("%0t:          actual   x=%0d y=%0d hd=%0d p=%0b e=%0b d=%0b",
						$realtime, pos_x, pos_y, heading, traj_present, at_end,
						points_dropped);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	int stall_count = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else if (stall_count >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("trajectory_point_interpolator regression: fail");
			$finish;
		end else
			stall_count <= stall_count + 1;
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_empty_and_single();
		send_item(CMD_QUERY, 40'd0, 0, 0, 0);
		send_item(CMD_UNUSED, 40'hff_ffff_ffff, -1, -1, -1);
		// append with nothing stored becomes the first point
		send_item(CMD_APPEND, 40'd500, 32'sh7fffffff, 32'sh80000000, 16'sd25736);
		send_item(CMD_QUERY, 40'hff_ffff_ffff, 0, 0, 0);
		send_item(CMD_FIRST, 40'd1000, -100, 200, -16'sd25736);
		send_item(CMD_QUERY, 40'd0, 0, 0, 0);
	endtask

	task automatic test_segments();
		send_item(CMD_APPEND, 40'd2000, 32'sh7fffffff, 32'sh80000000, 0);
		send_item(CMD_APPEND, 40'd2000, 0, 0, 16'sd100);        // zero-length
		send_item(CMD_APPEND, 40'd3000, 0, 0, 16'sd200);        // no motion
		send_item(CMD_APPEND, 40'd2500, -300, -5, 16'sd300);    // unsorted
		send_item(CMD_APPEND, 40'hff_ffff_ffff, 32'sh80000000, 32'sh7fffffff, 16'sd1);
		send_item(CMD_QUERY, 40'd999, 0, 0, 0);                 // before first
		send_item(CMD_QUERY, 40'd1000, 0, 0, 0);
		send_item(CMD_QUERY, 40'd1500, 0, 0, 0);                // tie rounding
		send_item(CMD_QUERY, 40'd1999, 0, 0, 0);
		send_item(CMD_QUERY, 40'd2000, 0, 0, 0);
		send_item(CMD_QUERY, 40'd2700, 0, 0, 0);
		send_item(CMD_QUERY, 40'h80_0000_0000, 0, 0, 0);
		send_item(CMD_QUERY, 40'hff_ffff_ffff, 0, 0, 0);        // at last point
	endtask

	task automatic test_overflow();
		send_item(CMD_FIRST, 40'd0, 0, 0, 0);
		for (int k = 1; k <= NPTS + 2; k++)
			send_item(CMD_APPEND, 40'(k * 100), rand_pos(), rand_pos(), rand_yaw());
		send_item(CMD_QUERY, 40'd6350, 0, 0, 0);
		send_item(CMD_QUERY, 40'd9999, 0, 0, 0);
		wait_drained();
		// first-point load clears the flag
		send_item(CMD_FIRST, 40'd5, 1, 2, 3);
		send_item(CMD_QUERY, 40'd5, 0, 0, 0);
	endtask

	task automatic test_random(int n_items);
		int sent = 0;
		int n;
		while (sent < n_items) begin
			n = $urandom_range(0, 5) == 0 ? $urandom_range(9, 20) : $urandom_range(2, 6);
			next_stamp = 40'($urandom_range(0, 100000));
			if ($urandom_range(0, 7) == 0)
				next_stamp = {$urandom, 8'($urandom)} >> 2;
			send_item($urandom_range(0, 1) ? CMD_FIRST : CMD_APPEND, next_stamp,
				rand_pos(), rand_pos(), rand_yaw());
			sent++;
			for (int k = 1; k < n; k++) begin
				// mostly increasing stamps, sometimes repeats or steps back
				case ($urandom_range(0, 9))
					0: next_stamp = next_stamp;
					1: next_stamp = next_stamp - 40'($urandom_range(0, 50));
					2: next_stamp = next_stamp + ({$urandom, 8'($urandom)} >> 6);
					default: next_stamp = next_stamp + 40'($urandom_range(1, 5000));
				endcase
				send_item(CMD_APPEND, next_stamp, rand_pos(), rand_pos(), rand_yaw());
				sent++;
			end
			repeat ($urandom_range(2, 8)) begin
				if ($urandom_range(0, 15) == 0)
					send_item(CMD_UNUSED, {$urandom, 8'($urandom)}, rand_pos(), 0, 0);
				else
					send_item(CMD_QUERY, $urandom_range(0, 3) == 0 ?
						{$urandom, 8'($urandom)} :
						next_stamp - 40'($urandom_range(0, 20000)), 0, 0, 0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_single();
		test_segments();
		wait_drained();  // sender holds until all results are back
		test_overflow();
		test_random(240);
		allow_gaps = 0;
		test_random(80);
		wait_drained();
		$display("covered %0d loads and %0d query results: empty, single point, hold,",
			loads_sent, queries_seen);
		$display("interpolation, zero-length and unsorted segments, capacity overflow");
		if (errors == 0)
			$display("trajectory_point_interpolator regression: pass");
		else
			$display("trajectory_point_interpolator regression: fail");
		$finish;
	end

endmodule

/* trajectory_point_interpolator.f */
sv/tpi_pkg.sv
sv/tpi_ram.sv
sv/tpi_ctrl.sv
sv/tpi_dp.sv
sv/trajectory_point_interpolator.sv
dv/trajectory_point_interpolator_test.sv
